// ===== rtl/hnm_pkg.sv =====
`default_nettype none

package hnm_pkg;

	localparam int MAX_STORED  = 1024;
	localparam int IDX_W       = $clog2(MAX_STORED);
	localparam int CNT_W       = $clog2(MAX_STORED + 1);
	localparam int WORD_W      = 64;
	localparam int WORDS       = 4;
	localparam int DESC_W      = WORD_W * WORDS;
	localparam int POP_W       = 7;
	localparam int DIST_W      = 9;
	localparam int RATIO_W     = 9;
	localparam int MATCH_IDX_W = 10;
	localparam int PROD_W      = DIST_W + RATIO_W;

	localparam logic [DIST_W-1:0]  FULL_DISTANCE = DIST_W'(256);
	localparam logic [RATIO_W-1:0] RATIO_RESET   = RATIO_W'(192);

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] desc_w0;
		logic [WORD_W-1:0] desc_w1;
		logic [WORD_W-1:0] desc_w2;
		logic [WORD_W-1:0] desc_w3;
	} in_item_t;

	typedef struct packed {
		logic                   matched;
		logic [MATCH_IDX_W-1:0] match_index;
		logic [DIST_W-1:0]      best_distance;
		logic [DIST_W-1:0]      second_distance;
	} out_item_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
	} tag_t;

	function automatic logic [5:0] pop32(input logic [31:0] v);
		logic [31:0] v1;
		logic [31:0] v2;
		logic [31:0] v3;
		logic [7:0]  s;
		v1 = v - ((v >> 1) & 32'h55555555);
		v2 = (v1 & 32'h33333333) + ((v1 >> 2) & 32'h33333333);
		v3 = (v2 + (v2 >> 4)) & 32'h0F0F0F0F;
		s  = v3[7:0] + v3[15:8] + v3[23:16] + v3[31:24];
		return s[5:0];
	endfunction

	function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
		return POP_W'(pop32(v[31:0])) + POP_W'(pop32(v[63:32]));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hnm_store.sv =====
`default_nettype none

module hnm_store (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [hnm_pkg::IDX_W-1:0]  waddr,
	input  wire logic [hnm_pkg::DESC_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [hnm_pkg::IDX_W-1:0]  raddr,
	output logic      [hnm_pkg::DESC_W-1:0] rdata
);
	import hnm_pkg::*;

	logic [DESC_W-1:0] mem_q [MAX_STORED];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hnm_dist.sv =====
`default_nettype none

module hnm_dist (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire hnm_pkg::tag_t             tag_s1,
	input  wire logic [hnm_pkg::DESC_W-1:0] entry_s1,
	input  wire logic [hnm_pkg::DESC_W-1:0] query,
	output hnm_pkg::tag_t                  tag_s3,
	output logic      [hnm_pkg::DIST_W-1:0] dist_s3
);
	import hnm_pkg::*;

	logic [DESC_W-1:0] diff;
	logic [POP_W-1:0]  pc_s2 [WORDS];
	tag_t              tag_s2;

	assign diff = entry_s1 ^ query;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < WORDS; w++) begin
			pc_s2[w] <= pop64(diff[w*WORD_W +: WORD_W]);
		end
		dist_s3 <= DIST_W'(pc_s2[0]) + DIST_W'(pc_s2[1])
			+ DIST_W'(pc_s2[2]) + DIST_W'(pc_s2[3]);
	end

endmodule

`default_nettype wire

// ===== rtl/hnm_rank.sv =====
`default_nettype none

module hnm_rank (
	input  wire logic                      clk,
	input  wire logic                      start,
	input  wire hnm_pkg::tag_t             tag,
	input  wire logic [hnm_pkg::DIST_W-1:0] cand_dist,
	output logic      [hnm_pkg::DIST_W-1:0] best,
	output logic      [hnm_pkg::DIST_W-1:0] second,
	output logic      [hnm_pkg::IDX_W-1:0]  near_idx
);
	import hnm_pkg::*;

	logic first;

	assign first = (tag.idx == '0);

	always_ff @(posedge clk) begin
		if (start) begin
			best     <= FULL_DISTANCE;
			second   <= FULL_DISTANCE;
			near_idx <= '0;
		end else if (tag.valid) begin
			if (first || cand_dist < best) begin
				if (!first) begin
					second <= best;
				end
				best     <= cand_dist;
				near_idx <= tag.idx;
			end else if (cand_dist < second) begin
				second <= cand_dist;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hamming_nn_ratio_matcher_core.sv =====
// Brute-force Hamming nearest-neighbor matcher with a ratio test.
// The input channel (in_valid, in_stall, in_data) carries one item per handshake:
// a load appends a 256-bit descriptor, a clear empties the set, a query searches it.
// Load and clear items leave the block idle, so they can follow back to back.
// Loads beyond capacity are dropped.
// A query reads the descriptor memory one entry per cycle. With entries stored, it
// moves through the scan, drain and finish steps: the scan feeds each entry through
// the memory read port into the shared XOR/popcount pipeline, the drain waits for the
// last distance, and the finish step writes the result. With an empty set the query
// goes straight to finish. in_stall stays high until the block is idle again.
// Each query gives one item on the output channel (out_valid, out_stall, out_data).
// The result sits in an output register; when the receiver stalls, it holds there,
// and a following query waits in its final step, with in_stall high, until the
// register is free. Loads and clears ahead of that query are still taken.
// The user keeps ratio register writes (cfg_we, cfg_wdata) to idle; the block does
// not enforce it. Reset empties the stored set and sets the ratio to 192/256. Memory
// contents are not cleared; only entries loaded since the last clear are ever read.
`default_nettype none

module hamming_nn_ratio_matcher_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire hnm_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output hnm_pkg::out_item_t              out_data,
	input  wire logic                       cfg_we,
	input  wire logic [hnm_pkg::RATIO_W-1:0] cfg_wdata
);
	import hnm_pkg::*;

	state_t             state_q, state_d;
	logic [RATIO_W-1:0] ratio_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   scan_q;
	logic [DESC_W-1:0]  query_q;
	logic [DESC_W-1:0]  in_desc;
	logic [DESC_W-1:0]  entry_s1;
	tag_t               tag_s1;
	tag_t               tag_s3;
	logic [DIST_W-1:0]  dist_s3;
	logic [DIST_W-1:0]  best;
	logic [DIST_W-1:0]  second;
	logic [IDX_W-1:0]   near_idx;
	logic               out_valid_q;
	out_item_t          out_q;
	out_item_t          result;
	logic               accept;
	logic               load_en;
	logic               clear_en;
	logic               query_start;
	logic               scan_en;
	logic               scan_last;
	logic               finish_fire;
	logic [PROD_W-1:0]  lhs;
	logic [PROD_W-1:0]  rhs;

	assign accept      = in_valid && !in_stall;
	assign load_en     = accept && (in_data.kind == KIND_LOAD) && (count_q < CNT_W'(MAX_STORED));
	assign clear_en    = accept && (in_data.kind == KIND_CLEAR);
	assign query_start = accept && (in_data.kind == KIND_QUERY);
	assign in_desc     = {in_data.desc_w3, in_data.desc_w2, in_data.desc_w1, in_data.desc_w0};
	assign scan_last   = (scan_q == n_q - CNT_W'(1));

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		scan_en     = 1'b0;
		finish_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (query_start) begin
					state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tag_s3.valid && tag_s3.last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					finish_fire = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ratio_q     <= RATIO_RESET;
			count_q     <= '0;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			tag_s1.valid <= scan_en;
			tag_s1.last  <= scan_en && scan_last;
			tag_s1.idx   <= scan_q[IDX_W-1:0];
			if (cfg_we) begin
				ratio_q <= cfg_wdata;
			end
			if (clear_en) begin
				count_q <= '0;
			end else if (load_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (finish_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_start) begin
			query_q <= in_desc;
			n_q     <= count_q;
			scan_q  <= '0;
		end else if (scan_en) begin
			scan_q <= scan_q + CNT_W'(1);
		end
		if (finish_fire) begin
			out_q <= result;
		end
	end

	hnm_store u_store (
		.clk   (clk),
		.we    (load_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_desc),
		.re    (scan_en),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (entry_s1)
	);

	hnm_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.entry_s1 (entry_s1),
		.query    (query_q),
		.tag_s3   (tag_s3),
		.dist_s3  (dist_s3)
	);

	hnm_rank u_rank (
		.clk       (clk),
		.start     (query_start),
		.tag       (tag_s3),
		.cand_dist (dist_s3),
		.best      (best),
		.second    (second),
		.near_idx  (near_idx)
	);

	assign lhs = PROD_W'({best, 8'd0});
	assign rhs = PROD_W'(second) * PROD_W'(ratio_q);

	always_comb begin
		result.matched         = (n_q >= CNT_W'(2)) && (lhs < rhs);
		result.match_index     = MATCH_IDX_W'(near_idx);
		result.best_distance   = best;
		result.second_distance = second;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/hnm_checker.sv =====
`default_nettype none

module hnm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire hnm_pkg::in_item_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire hnm_pkg::out_item_t out_data
);
	import hnm_pkg::*;

	// A result that is held back by the receiver stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output item changed or dropped");

	// A query keeps the input side busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.kind == KIND_QUERY |=> in_stall)
		else $error("input accepted during a query");

	// The nearest distance never exceeds the second nearest, and the second nearest never exceeds the full distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.best_distance <= out_data.second_distance
			&& out_data.second_distance <= FULL_DISTANCE)
		else $error("distance ordering violated");

	// A match is impossible when the second distance is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.matched |-> out_data.second_distance != '0)
		else $error("match reported with a zero second distance");

endmodule

bind hamming_nn_ratio_matcher_core hnm_checker u_hnm_checker (.*);

`default_nettype wire
